[hdl/bmst_pkg.sv]
package bmst_pkg;

	localparam int MAX_VERTS = 16;
	localparam int MAX_EDGES = 32;
	localparam int COST_BITS = 16;

	localparam int VID_W   = 5;
	localparam int VIX_W   = $clog2(MAX_VERTS);
	localparam int EADDR_W = $clog2(MAX_EDGES);
	localparam int ECNT_W  = EADDR_W + 1;
	localparam int TCOST_W = 20;
	localparam int TEDGE_W = 4;

	localparam logic [VID_W-1:0] VC_RESET = VID_W'(6);
	localparam logic [VID_W-1:0] VC_MIN   = VID_W'(2);
	localparam logic [VID_W-1:0] VC_MAX   = VID_W'(MAX_VERTS);

	typedef struct packed {
		logic [VID_W-1:0]     src;
		logic [VID_W-1:0]     dst;
		logic [COST_BITS-1:0] cost;
	} edge_t;

	typedef struct packed {
		logic               en;
		logic [EADDR_W-1:0] addr;
		edge_t              data;
	} ram_wr_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ROUND,
		ST_RD,
		ST_FA,
		ST_FB,
		ST_OA,
		ST_OB,
		ST_JA,
		ST_JB,
		ST_JU,
		ST_JEND,
		ST_DONE
	} state_t;

endpackage

[hdl/bmst_edge_ram.sv]
module bmst_edge_ram
	import bmst_pkg::*;
(
	input  logic               clk,
	input  ram_wr_t            wr,
	input  logic [EADDR_W-1:0] raddr,
	output edge_t              rdata
);

	edge_t mem [MAX_EDGES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/bmst_less.sv]
module bmst_less
	import bmst_pkg::*;
(
	input  logic [COST_BITS-1:0] a,
	input  logic [COST_BITS-1:0] b,
	output logic                 lt
);

	assign lt = (a < b);

endmodule

[hdl/boruvka_mst_weight.sv]
// Minimum spanning tree weight by Boruvka rounds. Edges stream in one per
// cycle (edge_stall low) into a 32-entry edge store; extra edges are dropped
// and reported in overflow. The edge marked last starts the solve, during
// which edge_stall stays high. Each round scans every stored edge (store
// read, two component lookups for an edge in range, two cheapest-edge
// offers through one shared cost comparator for an edge across components),
// then walks the components to join them. A solve runs at most
// log2(vertices) + 1 rounds. Ties on cost go to the edge that arrived first.
// One result comes out per graph; the next graph may load while that result
// waits.
module boruvka_mst_weight
	import bmst_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [VID_W-1:0]     vertex_count,
	input  logic                 edge_valid,
	output logic                 edge_stall,
	input  logic [VID_W-1:0]     edge_from,
	input  logic [VID_W-1:0]     edge_to,
	input  logic [COST_BITS-1:0] edge_cost,
	input  logic                 last_edge,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [TCOST_W-1:0]   tree_cost,
	output logic [TEDGE_W-1:0]   tree_edges,
	output logic                 connected,
	output logic                 overflow
);

	state_t state_q, state_d;

	logic [VID_W-1:0]     vc_cfg_q;
	logic [VID_W-1:0]     vc_q;
	logic [ECNT_W-1:0]    edge_total_q;
	logic                 overflow_q;
	logic [ECNT_W-1:0]    e_q;
	logic [VID_W-1:0]     i_q;
	logic [VIX_W-1:0]     la_q, lb_q;
	logic                 progress_q;
	logic [TCOST_W-1:0]   total_q;
	logic [TEDGE_W-1:0]   joined_q;

	logic [VIX_W-1:0]     label_q   [MAX_VERTS];
	logic [MAX_VERTS-1:0] cv_q;
	logic [VIX_W-1:0]     ch_src_q  [MAX_VERTS];
	logic [VIX_W-1:0]     ch_dst_q  [MAX_VERTS];
	logic [COST_BITS-1:0] ch_cost_q [MAX_VERTS];

	logic                 res_valid_q;
	logic [TCOST_W-1:0]   res_cost_q;
	logic [TEDGE_W-1:0]   res_edges_q;
	logic                 res_conn_q;
	logic                 res_ovf_q;

	ram_wr_t              ram_wr;
	edge_t                rd;
	logic                 in_xfer;
	logic                 usable;
	logic [VIX_W-1:0]     src_idx, dst_idx;
	logic [VIX_W-1:0]     lidx, cidx;
	logic [VIX_W-1:0]     label_rd;
	logic                 lt;
	logic                 take;
	logic [ECNT_W-1:0]    e_next;
	logic                 e_last;
	logic                 i_last;
	logic                 out_free;
	logic                 all_joined;

	function automatic logic [VID_W-1:0] clamp_vc(input logic [VID_W-1:0] v);
		if (v < VC_MIN) return VC_MIN;
		if (v > VC_MAX) return VC_MAX;
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_xfer   = edge_valid && !edge_stall;

	assign ram_wr.en   = in_xfer && (edge_total_q < ECNT_W'(MAX_EDGES));
	assign ram_wr.addr = edge_total_q[EADDR_W-1:0];
	assign ram_wr.data = '{src: edge_from, dst: edge_to, cost: edge_cost};

	bmst_edge_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (e_q[EADDR_W-1:0]),
		.rdata (rd)
	);

	assign usable = (rd.src != '0) && (rd.src <= vc_q) &&
	                (rd.dst != '0) && (rd.dst <= vc_q);
	assign src_idx = VIX_W'(rd.src - VID_W'(1));
	assign dst_idx = VIX_W'(rd.dst - VID_W'(1));

	// one shared cost comparator serves both offers of an edge
	bmst_less u_less (
		.a  (rd.cost),
		.b  (ch_cost_q[cidx]),
		.lt (lt)
	);

	assign label_rd   = label_q[lidx];
	assign take       = !cv_q[cidx] || lt;
	assign e_next     = e_q + ECNT_W'(1);
	assign e_last     = (e_next == edge_total_q);
	assign i_last     = ((i_q + VID_W'(1)) == vc_q);
	assign out_free   = !res_valid_q || !result_stall;
	assign all_joined = ({1'b0, joined_q} == (vc_q - VID_W'(1)));

	// output / address selection
	always_comb begin
		edge_stall = 1'b1;
		lidx       = src_idx;
		cidx       = la_q;
		case (state_q)
			ST_LOAD: edge_stall = 1'b0;
			ST_FA:   lidx = src_idx;
			ST_FB:   lidx = dst_idx;
			ST_OA:   cidx = la_q;
			ST_OB:   cidx = lb_q;
			ST_JA: begin
				cidx = i_q[VIX_W-1:0];
				lidx = ch_src_q[i_q[VIX_W-1:0]];
			end
			ST_JB: begin
				cidx = i_q[VIX_W-1:0];
				lidx = ch_dst_q[i_q[VIX_W-1:0]];
			end
			ST_JU:   cidx = i_q[VIX_W-1:0];
			default: edge_stall = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (in_xfer && last_edge) state_d = ST_ROUND;
			ST_ROUND: state_d = (edge_total_q == '0) ? ST_JA : ST_RD;
			ST_RD:    state_d = ST_FA;
			ST_FA: begin
				if (usable) state_d = ST_FB;
				else state_d = e_last ? ST_JA : ST_RD;
			end
			ST_FB: begin
				if (label_rd != la_q) state_d = ST_OA;
				else state_d = e_last ? ST_JA : ST_RD;
			end
			ST_OA:    state_d = ST_OB;
			ST_OB:    state_d = e_last ? ST_JA : ST_RD;
			ST_JA: begin
				if (cv_q[i_q[VIX_W-1:0]]) state_d = ST_JB;
				else state_d = i_last ? ST_JEND : ST_JA;
			end
			ST_JB:    state_d = ST_JU;
			ST_JU:    state_d = i_last ? ST_JEND : ST_JA;
			ST_JEND:  state_d = (!progress_q || all_joined) ? ST_DONE : ST_ROUND;
			ST_DONE:  if (out_free) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			vc_cfg_q     <= VC_RESET;
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
			cv_q         <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) vc_cfg_q <= vertex_count;
			if (in_xfer) begin
				if (edge_total_q < ECNT_W'(MAX_EDGES)) edge_total_q <= edge_total_q + ECNT_W'(1);
				else overflow_q <= 1'b1;
			end
			if (state_q == ST_ROUND) cv_q <= '0;
			if ((state_q == ST_OA || state_q == ST_OB) && take) cv_q[cidx] <= 1'b1;
			if (state_q == ST_DONE && out_free) begin
				edge_total_q <= '0;
				overflow_q   <= 1'b0;
				res_valid_q  <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// solve datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && last_edge) begin
					vc_q       <= clamp_vc(vc_cfg_q);
					total_q    <= '0;
					joined_q   <= '0;
					for (int j = 0; j < MAX_VERTS; j++) label_q[j] <= VIX_W'(j);
				end
			end
			ST_ROUND: begin
				e_q        <= '0;
				i_q        <= '0;
				progress_q <= 1'b0;
			end
			ST_FA: begin
				la_q <= label_rd;
				if (!usable) e_q <= e_next;
			end
			ST_FB: begin
				lb_q <= label_rd;
				if (label_rd == la_q) e_q <= e_next;
			end
			ST_OA, ST_OB: begin
				if (take) begin
					ch_src_q[cidx]  <= src_idx;
					ch_dst_q[cidx]  <= dst_idx;
					ch_cost_q[cidx] <= rd.cost;
				end
				if (state_q == ST_OB) e_q <= e_next;
			end
			ST_JA: begin
				la_q <= label_rd;
				if (!cv_q[i_q[VIX_W-1:0]]) i_q <= i_q + VID_W'(1);
			end
			ST_JB: lb_q <= label_rd;
			ST_JU: begin
				if (la_q != lb_q) begin
					// merge component la into lb
					for (int j = 0; j < MAX_VERTS; j++) begin
						if (label_q[j] == la_q) label_q[j] <= lb_q;
					end
					total_q    <= total_q + TCOST_W'(ch_cost_q[cidx]);
					joined_q   <= joined_q + TEDGE_W'(1);
					progress_q <= 1'b1;
				end
				i_q <= i_q + VID_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					res_cost_q  <= total_q;
					res_edges_q <= joined_q;
					res_conn_q  <= all_joined;
					res_ovf_q   <= overflow_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = res_valid_q;
	assign tree_cost    = res_cost_q;
	assign tree_edges   = res_edges_q;
	assign connected    = res_conn_q;
	assign overflow     = res_ovf_q;

endmodule

[hdl/bmst_checker.sv]
module bmst_checker
	import bmst_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 edge_valid,
	input logic                 edge_stall,
	input logic                 last_edge,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic [TCOST_W-1:0]   tree_cost,
	input logic [TEDGE_W-1:0]   tree_edges,
	input logic                 connected
);

	// the solve holds off edges right after the last one
	a_solve_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		edge_valid && !edge_stall && last_edge |=> edge_stall)
		else $error("edge accepted right after last edge");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(tree_cost))
		else $error("stalled result changed");

	// a connected graph of at least two vertices needs an edge
	a_conn_edges: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && connected |-> tree_edges != '0)
		else $error("connected with no edges");

	a_res_after_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(edge_stall))
		else $error("result without solve");

endmodule

bind boruvka_mst_weight bmst_checker u_bmst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.edge_valid   (edge_valid),
	.edge_stall   (edge_stall),
	.last_edge    (last_edge),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.tree_cost    (tree_cost),
	.tree_edges   (tree_edges),
	.connected    (connected)
);
